@@ hw/rtl/pot_pkg.sv @@
// Shared types, constants and helper functions for the pad overlap test block
`default_nettype none

package pot_pkg;

    localparam int CW     = 32;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_TOUCH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STRICT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ANY    = 2'd2;

    typedef logic signed [CW-1:0]   coord_t;
    typedef logic        [CW-2:0]   radius_t;
    typedef logic        [CW-1:0]   span_t;
    typedef logic signed [CW:0]     diff_t;
    typedef logic        [2*CW+1:0] sq_t;
    typedef logic        [2*CW+2:0] sqsum_t;

    typedef struct packed {
        coord_t xl;
        coord_t yl;
        coord_t xh;
        coord_t yh;
    } box_t;

    typedef struct packed {
        logic    rnd;
        box_t    box;
        radius_t r;
        coord_t  c0x;
        coord_t  c0y;
        coord_t  c2x;
        coord_t  c2y;
        coord_t  rx0;
        coord_t  ry0;
        coord_t  rx1;
        coord_t  ry1;
    } pad_prims_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } front_en_t;

    typedef struct packed {
        coord_t a_x0;
        coord_t a_y0;
        coord_t a_x1;
        coord_t a_y1;
        logic   a_rounded;
        coord_t b_x0;
        coord_t b_y0;
        coord_t b_x1;
        coord_t b_y1;
        logic   b_rounded;
    } in_beat_t;

    typedef struct packed {
        logic overlaps;
        logic a_inside_b;
    } out_beat_t;

    function automatic diff_t sub_ext(coord_t p, coord_t q);
        diff_t pe;
        diff_t qe;
        pe = {p[CW-1], p};
        qe = {q[CW-1], q};
        return pe - qe;
    endfunction

    function automatic sq_t square(diff_t d);
        logic signed [2*CW+1:0] de;
        logic signed [2*CW+1:0] p;
        de = {{(CW+1){d[CW]}}, d};
        p  = de * de;
        return sq_t'(p);
    endfunction

    function automatic logic circ_rect(coord_t cx, coord_t cy, radius_t r,
                                       coord_t x0, coord_t y0,
                                       coord_t x1, coord_t y1, logic strict);
        diff_t re;
        diff_t lx;
        diff_t hx;
        diff_t ly;
        diff_t hy;
        diff_t cxe;
        diff_t cye;
        re  = {2'b00, r};
        lx  = diff_t'({x0[CW-1], x0}) - re;
        hx  = diff_t'({x1[CW-1], x1}) + re;
        ly  = diff_t'({y0[CW-1], y0}) - re;
        hy  = diff_t'({y1[CW-1], y1}) + re;
        cxe = {cx[CW-1], cx};
        cye = {cy[CW-1], cy};
        if (strict)
        begin
            return (cxe > lx) && (cxe < hx) && (cye > ly) && (cye < hy);
        end
        return (cxe >= lx) && (cxe <= hx) && (cye >= ly) && (cye <= hy);
    endfunction

    function automatic logic rect_rect(coord_t px0, coord_t py0, coord_t px1, coord_t py1,
                                       coord_t qx0, coord_t qy0, coord_t qx1, coord_t qy1,
                                       logic strict);
        if (strict)
        begin
            return (px1 > qx0) && (qx1 > px0) && (py1 > qy0) && (qy1 > py0);
        end
        return (px1 >= qx0) && (qx1 >= px0) && (py1 >= qy0) && (qy1 >= py0);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pot_if.sv @@
// Handshake channel interfaces for pad pairs, results and mode writes
`default_nettype none

interface pot_in_if;
    import pot_pkg::*;
    logic     valid;
    logic     ready;
    in_beat_t beat;
    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

interface pot_out_if;
    import pot_pkg::*;
    logic      valid;
    logic      ready;
    out_beat_t beat;
    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

interface pot_cfg_if;
    import pot_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pot_pad_front.sv @@
// Four-stage pad front end: sort corners, measure, pick radius, split into primitives
`default_nettype none

module pot_pad_front (
    input  wire                 clk,
    input  pot_pkg::front_en_t  en,
    input  pot_pkg::coord_t     x0,
    input  pot_pkg::coord_t     y0,
    input  pot_pkg::coord_t     x1,
    input  pot_pkg::coord_t     y1,
    input  wire                 rounded,
    output pot_pkg::pad_prims_t prims
);
    import pot_pkg::*;

    box_t       box1_next;
    box_t       box1_reg;
    logic       rnd1_reg;

    span_t      w2_next;
    span_t      h2_next;
    span_t      w2_reg;
    span_t      h2_reg;
    box_t       box2_reg;
    logic       rnd2_reg;

    logic       tall3_next;
    radius_t    r3_next;
    logic       tall3_reg;
    radius_t    r3_reg;
    box_t       box3_reg;
    logic       rnd3_reg;

    coord_t     r_ext;
    coord_t     xl_r;
    coord_t     yl_r;
    coord_t     xh_r;
    coord_t     yh_r;
    pad_prims_t prims4_next;
    pad_prims_t prims4_reg;

    always_comb
    begin
        box1_next.xl = (x0 < x1) ? x0 : x1;
        box1_next.xh = (x0 < x1) ? x1 : x0;
        box1_next.yl = (y0 < y1) ? y0 : y1;
        box1_next.yh = (y0 < y1) ? y1 : y0;
    end

    assign w2_next = span_t'(box1_reg.xh - box1_reg.xl);
    assign h2_next = span_t'(box1_reg.yh - box1_reg.yl);

    assign tall3_next = h2_reg > w2_reg;
    assign r3_next    = tall3_next ? w2_reg[CW-1:1] : h2_reg[CW-1:1];

    assign r_ext = {1'b0, r3_reg};
    assign xl_r  = box3_reg.xl + r_ext;
    assign yl_r  = box3_reg.yl + r_ext;
    assign xh_r  = box3_reg.xh - r_ext;
    assign yh_r  = box3_reg.yh - r_ext;

    always_comb
    begin
        prims4_next.rnd = rnd3_reg;
        prims4_next.box = box3_reg;
        prims4_next.r   = r3_reg;
        prims4_next.c0x = xl_r;
        prims4_next.c0y = tall3_reg ? yh_r : yl_r;
        prims4_next.c2x = tall3_reg ? xl_r : xh_r;
        prims4_next.c2y = yl_r;
        if (!rnd3_reg)
        begin
            prims4_next.rx0 = box3_reg.xl;
            prims4_next.ry0 = box3_reg.yl;
            prims4_next.rx1 = box3_reg.xh;
            prims4_next.ry1 = box3_reg.yh;
        end
        else if (tall3_reg)
        begin
            prims4_next.rx0 = box3_reg.xl;
            prims4_next.ry0 = yl_r;
            prims4_next.rx1 = box3_reg.xh;
            prims4_next.ry1 = yh_r;
        end
        else
        begin
            prims4_next.rx0 = xl_r;
            prims4_next.ry0 = box3_reg.yl;
            prims4_next.rx1 = xh_r;
            prims4_next.ry1 = box3_reg.yh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            box1_reg <= box1_next;
            rnd1_reg <= rounded;
        end
        if (en.s2)
        begin
            w2_reg   <= w2_next;
            h2_reg   <= h2_next;
            box2_reg <= box1_reg;
            rnd2_reg <= rnd1_reg;
        end
        if (en.s3)
        begin
            tall3_reg <= tall3_next;
            r3_reg    <= r3_next;
            box3_reg  <= box2_reg;
            rnd3_reg  <= rnd2_reg;
        end
        if (en.s4)
        begin
            prims4_reg <= prims4_next;
        end
    end

    assign prims = prims4_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pad_overlap_test_core.sv @@
// Pad overlap test core: pipelined primitive-pair overlap and containment test
// Accepts one pad pair per cycle while the result channel does not stall and returns one
// result per pair. Stages one to four sort each pad and split it into end circles and a
// middle rectangle, stage five forms center differences and runs the box tests, stage six
// holds the 33-bit squarers, stage seven compares distances and is the output register. Each
// stage advances on its own, so bubbles close up under stall.
`default_nettype none

module pad_overlap_test_core (
    input  wire          clk,
    input  wire          rst_n,
    pot_in_if.sink       pads,
    pot_out_if.source    result,
    pot_cfg_if.sink      cfg
);
    import pot_pkg::*;

    localparam int NST = 7;

    logic [MODE_W-1:0] mode_reg;
    logic              strict;

    logic [NST:1] v_reg;
    logic [NST:1] v_next;
    logic [NST:1] adv;

    front_en_t  fen;
    pad_prims_t pa;
    pad_prims_t pb;

    diff_t dx5_next [4];
    diff_t dy5_next [4];
    diff_t dx5_reg  [4];
    diff_t dy5_reg  [4];
    span_t rsum5_next;
    span_t rsum5_reg;
    logic  hit5_next;
    logic  hit5_reg;
    logic  cc5_next;
    logic  cc5_reg;
    logic  in5_next;
    logic  in5_reg;

    sq_t   sqx6_next [4];
    sq_t   sqy6_next [4];
    sq_t   sqx6_reg  [4];
    sq_t   sqy6_reg  [4];
    logic [2*CW-1:0] rprod;
    sq_t   rsq6_next;
    sq_t   rsq6_reg;
    logic  hit6_reg;
    logic  cc6_reg;
    logic  in6_reg;

    sqsum_t    d2 [4];
    sqsum_t    r2;
    logic [3:0] cc_hit;
    out_beat_t out7_next;
    out_beat_t out7_reg;

    assign strict = (mode_reg == MODE_STRICT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TOUCH;
        end
        else if (cfg.valid)
        begin
            mode_reg <= cfg.data;
        end
    end

    assign cfg.ready = 1'b1;

    always_comb
    begin
        adv[NST] = !v_reg[NST] || result.ready;
        for (int i = NST - 1; i >= 1; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    always_comb
    begin
        v_next = v_reg;
        if (adv[1])
        begin
            v_next[1] = pads.valid;
        end
        for (int i = 2; i <= NST; i++)
        begin
            if (adv[i])
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign pads.ready = adv[1];

    assign fen.s1 = adv[1];
    assign fen.s2 = adv[2];
    assign fen.s3 = adv[3];
    assign fen.s4 = adv[4];

    pot_pad_front u_front_a (
        .clk     (clk),
        .en      (fen),
        .x0      (pads.beat.a_x0),
        .y0      (pads.beat.a_y0),
        .x1      (pads.beat.a_x1),
        .y1      (pads.beat.a_y1),
        .rounded (pads.beat.a_rounded),
        .prims   (pa)
    );

    pot_pad_front u_front_b (
        .clk     (clk),
        .en      (fen),
        .x0      (pads.beat.b_x0),
        .y0      (pads.beat.b_y0),
        .x1      (pads.beat.b_x1),
        .y1      (pads.beat.b_y1),
        .rounded (pads.beat.b_rounded),
        .prims   (pb)
    );

    // pair k: a circle (k[1] ? end 2 : end 0) against b circle (k[0] ? end 2 : end 0)
    always_comb
    begin
        dx5_next[0] = sub_ext(pa.c0x, pb.c0x);
        dy5_next[0] = sub_ext(pa.c0y, pb.c0y);
        dx5_next[1] = sub_ext(pa.c0x, pb.c2x);
        dy5_next[1] = sub_ext(pa.c0y, pb.c2y);
        dx5_next[2] = sub_ext(pa.c2x, pb.c0x);
        dy5_next[2] = sub_ext(pa.c2y, pb.c0y);
        dx5_next[3] = sub_ext(pa.c2x, pb.c2x);
        dy5_next[3] = sub_ext(pa.c2y, pb.c2y);
        rsum5_next  = span_t'({1'b0, pa.r}) + span_t'({1'b0, pb.r});
        hit5_next   =
            (pa.rnd && (circ_rect(pa.c0x, pa.c0y, pa.r,
                                  pb.rx0, pb.ry0, pb.rx1, pb.ry1, strict) ||
                        circ_rect(pa.c2x, pa.c2y, pa.r,
                                  pb.rx0, pb.ry0, pb.rx1, pb.ry1, strict))) ||
            (pb.rnd && (circ_rect(pb.c0x, pb.c0y, pb.r,
                                  pa.rx0, pa.ry0, pa.rx1, pa.ry1, strict) ||
                        circ_rect(pb.c2x, pb.c2y, pb.r,
                                  pa.rx0, pa.ry0, pa.rx1, pa.ry1, strict))) ||
            rect_rect(pa.rx0, pa.ry0, pa.rx1, pa.ry1,
                      pb.rx0, pb.ry0, pb.rx1, pb.ry1, strict);
        cc5_next    = pa.rnd && pb.rnd;
        in5_next    = (pa.box.xl >= pb.box.xl) && (pa.box.xh <= pb.box.xh) &&
                      (pa.box.yl >= pb.box.yl) && (pa.box.yh <= pb.box.yh);
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sqx6_next[k] = square(dx5_reg[k]);
            sqy6_next[k] = square(dy5_reg[k]);
        end
        rprod     = rsum5_reg * rsum5_reg;
        rsq6_next = {2'b00, rprod};
    end

    always_comb
    begin
        r2 = {1'b0, rsq6_reg};
        for (int k = 0; k < 4; k++)
        begin
            d2[k]     = sqsum_t'({1'b0, sqx6_reg[k]}) + sqsum_t'({1'b0, sqy6_reg[k]});
            cc_hit[k] = strict ? (d2[k] < r2) : (d2[k] <= r2);
        end
        out7_next.overlaps   = (mode_reg < MODE_ANY) && (hit6_reg || (cc6_reg && (|cc_hit)));
        out7_next.a_inside_b = in6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            dx5_reg   <= dx5_next;
            dy5_reg   <= dy5_next;
            rsum5_reg <= rsum5_next;
            hit5_reg  <= hit5_next;
            cc5_reg   <= cc5_next;
            in5_reg   <= in5_next;
        end
        if (adv[6])
        begin
            sqx6_reg <= sqx6_next;
            sqy6_reg <= sqy6_next;
            rsq6_reg <= rsq6_next;
            hit6_reg <= hit5_reg;
            cc6_reg  <= cc5_reg;
            in6_reg  <= in5_reg;
        end
        if (adv[7])
        begin
            out7_reg <= out7_next;
        end
    end

    assign result.valid = v_reg[NST];
    assign result.beat  = out7_reg;

endmodule

`default_nettype wire

@@ tb/pad_overlap_test_monitor.sv @@
// Pad overlap monitor: predicts each pad-pair result, checks the result channel, counts failures
`default_nettype none

module pad_overlap_test_monitor (
    input  wire  clk,
    input  wire  rst_n,
    pot_in_if    pads,
    pot_out_if   result,
    pot_cfg_if   cfg,
    output int   fails,
    output int   pending,
    output int   checked,
    output int   hits,
    output int   enclosed
);
    timeunit 1ns;
    timeprecision 1ps;

    import pot_pkg::*;

    typedef logic signed [95:0] wide_t;

    typedef struct packed {
        logic   circ;
        longint cx;
        longint cy;
        longint r;
        longint x0;
        longint y0;
        longint x1;
        longint y1;
    } shape_t;

    logic [MODE_W-1:0] mode_q;
    out_beat_t         due[$];
    out_beat_t         want;
    int                fail_cnt = 0;
    int                check_cnt = 0;
    int                hit_cnt = 0;
    int                encl_cnt = 0;

    // k selects first end circle, middle rectangle, second end circle; an unrounded pad is its whole box
    function automatic shape_t pad_part(longint xl, longint yl, longint xh, longint yh,
                                        logic rnd, int k);
        shape_t s;
        longint w;
        longint h;
        longint r;
        s = '0;
        w = xh - xl;
        h = yh - yl;
        if (!rnd)
        begin
            s.x0 = xl;
            s.y0 = yl;
            s.x1 = xh;
            s.y1 = yh;
            return s;
        end
        s.circ = (k != 1);
        if (h > w)
        begin
            r = w / 2;
            s.r = r;
            s.cx = xl + r;
            s.cy = (k == 0) ? yh - r : yl + r;
            s.x0 = xl;
            s.y0 = yl + r;
            s.x1 = xh;
            s.y1 = yh - r;
        end
        else
        begin
            r = h / 2;
            s.r = r;
            s.cx = (k == 0) ? xl + r : xh - r;
            s.cy = yl + r;
            s.x0 = xl + r;
            s.y0 = yl;
            s.x1 = xh - r;
            s.y1 = yh;
        end
        if (s.circ)
        begin
            s.x0 = 0;
            s.y0 = 0;
            s.x1 = 0;
            s.y1 = 0;
        end
        else
        begin
            s.r = 0;
            s.cx = 0;
            s.cy = 0;
        end
        return s;
    endfunction

    function automatic logic disc_hits_box(shape_t c, shape_t b, logic strict);
        longint lx;
        longint hx;
        longint ly;
        longint hy;
        lx = b.x0 - c.r;
        hx = b.x1 + c.r;
        ly = b.y0 - c.r;
        hy = b.y1 + c.r;
        if (strict)
        begin
            return c.cx > lx && c.cx < hx && c.cy > ly && c.cy < hy;
        end
        return c.cx >= lx && c.cx <= hx && c.cy >= ly && c.cy <= hy;
    endfunction

    function automatic logic shapes_meet(shape_t p, shape_t q, logic strict);
        wide_t dx;
        wide_t dy;
        wide_t rs;
        wide_t d2;
        wide_t r2;
        if (p.circ && q.circ)
        begin
            dx = p.cx - q.cx;
            dy = p.cy - q.cy;
            rs = p.r + q.r;
            d2 = dx * dx + dy * dy;
            r2 = rs * rs;
            return strict ? (d2 < r2) : (d2 <= r2);
        end
        if (p.circ)
        begin
            return disc_hits_box(p, q, strict);
        end
        if (q.circ)
        begin
            return disc_hits_box(q, p, strict);
        end
        if (strict)
        begin
            return p.x1 > q.x0 && q.x1 > p.x0 && p.y1 > q.y0 && q.y1 > p.y0;
        end
        return p.x1 >= q.x0 && q.x1 >= p.x0 && p.y1 >= q.y0 && q.y1 >= p.y0;
    endfunction

    function automatic out_beat_t judge_pair(in_beat_t b, logic [MODE_W-1:0] m);
        out_beat_t o;
        longint    axl;
        longint    ayl;
        longint    axh;
        longint    ayh;
        longint    bxl;
        longint    byl;
        longint    bxh;
        longint    byh;
        int        na;
        int        nb;
        logic      strict;
        axl = (b.a_x0 < b.a_x1) ? b.a_x0 : b.a_x1;
        axh = (b.a_x0 < b.a_x1) ? b.a_x1 : b.a_x0;
        ayl = (b.a_y0 < b.a_y1) ? b.a_y0 : b.a_y1;
        ayh = (b.a_y0 < b.a_y1) ? b.a_y1 : b.a_y0;
        bxl = (b.b_x0 < b.b_x1) ? b.b_x0 : b.b_x1;
        bxh = (b.b_x0 < b.b_x1) ? b.b_x1 : b.b_x0;
        byl = (b.b_y0 < b.b_y1) ? b.b_y0 : b.b_y1;
        byh = (b.b_y0 < b.b_y1) ? b.b_y1 : b.b_y0;
        na = b.a_rounded ? 3 : 1;
        nb = b.b_rounded ? 3 : 1;
        strict = (m == MODE_STRICT);
        o.overlaps = 1'b0;
        o.a_inside_b = (axl >= bxl) && (axh <= bxh) && (ayl >= byl) && (ayh <= byh);
        if (m == MODE_TOUCH || m == MODE_STRICT)
        begin
            for (int i = 0; i < na; i++)
            begin
                for (int j = 0; j < nb; j++)
                begin
                    if (shapes_meet(pad_part(axl, ayl, axh, ayh, b.a_rounded, i),
                                    pad_part(bxl, byl, bxh, byh, b.b_rounded, j), strict))
                    begin
                        o.overlaps = 1'b1;
                    end
                end
            end
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q <= MODE_TOUCH;
            due.delete();
            pending <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (due.size() == 0)
                begin
                    $display("%0t: result beat overlaps=%b a_inside_b=%b with nothing expected",
                             $time, result.beat.overlaps, result.beat.a_inside_b);
                    fail_cnt++;
                end
                else
                begin
                    want = due.pop_front();
                    check_cnt++;
                    if (result.beat.overlaps !== want.overlaps)
                    begin
                        $display("%0t: overlaps expected %b, got %b",
                                 $time, want.overlaps, result.beat.overlaps);
                        fail_cnt++;
                    end
                    if (result.beat.a_inside_b !== want.a_inside_b)
                    begin
                        $display("%0t: a_inside_b expected %b, got %b",
                                 $time, want.a_inside_b, result.beat.a_inside_b);
                        fail_cnt++;
                    end
                    if (want.overlaps)
                    begin
                        hit_cnt++;
                    end
                    if (want.a_inside_b)
                    begin
                        encl_cnt++;
                    end
                end
            end
            if (pads.valid && pads.ready)
            begin
                due.push_back(judge_pair(pads.beat, mode_q));
            end
            if (cfg.valid && cfg.ready)
            begin
                mode_q <= cfg.data;
            end
            pending  <= due.size();
            fails    <= fail_cnt;
            checked  <= check_cnt;
            hits     <= hit_cnt;
            enclosed <= encl_cnt;
        end
    end

endmodule

`default_nettype wire

@@ tb/pad_overlap_test_core_test.sv @@
// Pad overlap core testbench top: clock, reset, pad-pair and mode stimulus, verdict
`default_nettype none

module pad_overlap_test_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pot_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam int PHASES       = 8;
    localparam int PHASE_PAIRS  = 240;
    localparam int HOLD_CYCLES  = 80;
    localparam int FLUSH_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 300000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic gaps_on = 1'b1;
    logic stalls_on = 1'b1;
    logic hold_long = 1'b0;
    int   cycle_cnt = 0;
    int   pairs_sent = 0;
    int   fails;
    int   pending;
    int   checked;
    int   hits;
    int   enclosed;

    logic [MODE_W-1:0] phase_mode [PHASES] = '{MODE_STRICT, MODE_TOUCH, MODE_ANY, MODE_STRICT,
                                               MODE_SPARE, MODE_TOUCH, MODE_STRICT, MODE_TOUCH};

    pot_in_if  pads ();
    pot_out_if result ();
    pot_cfg_if cfg ();

    pad_overlap_test_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pads   (pads),
        .result (result),
        .cfg    (cfg)
    );

    pad_overlap_test_monitor overlap_mon (
        .clk      (clk),
        .rst_n    (rst_n),
        .pads     (pads),
        .result   (result),
        .cfg      (cfg),
        .fails    (fails),
        .pending  (pending),
        .checked  (checked),
        .hits     (hits),
        .enclosed (enclosed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic in_beat_t pair_of(coord_t ax0, coord_t ay0, coord_t ax1, coord_t ay1,
                                         logic ar, coord_t bx0, coord_t by0, coord_t bx1,
                                         coord_t by1, logic br);
        in_beat_t p;
        p.a_x0 = ax0;
        p.a_y0 = ay0;
        p.a_x1 = ax1;
        p.a_y1 = ay1;
        p.a_rounded = ar;
        p.b_x0 = bx0;
        p.b_y0 = by0;
        p.b_x1 = bx1;
        p.b_y1 = by1;
        p.b_rounded = br;
        return p;
    endfunction

    function automatic coord_t pick_coord(int scale);
        case (scale)
            0: return coord_t'($urandom_range(0, 48)) - 24;
            1: return coord_t'($urandom_range(0, 1 << 20)) - (1 << 19);
            2: return coord_t'($urandom);
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return C_MAX - coord_t'($urandom_range(0, 3));
                    1: return C_MIN + coord_t'($urandom_range(0, 3));
                    2: return coord_t'($urandom_range(0, 3)) - 2;
                    default: return coord_t'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic in_beat_t rand_pair();
        in_beat_t p;
        int       pick;
        int       scale;
        coord_t   lo_x;
        coord_t   hi_x;
        coord_t   lo_y;
        coord_t   hi_y;
        coord_t   dx;
        coord_t   dy;
        coord_t   t;
        pick = $urandom_range(0, 9);
        scale = (pick < 5) ? 0 : (pick < 7) ? 1 : (pick < 9) ? 2 : 3;
        p.a_x0 = pick_coord(scale);
        p.a_y0 = pick_coord(scale);
        p.a_x1 = pick_coord(scale);
        p.a_y1 = pick_coord(scale);
        p.a_rounded = 1'($urandom_range(0, 1));
        p.b_rounded = 1'($urandom_range(0, 1));
        lo_x = (p.a_x0 < p.a_x1) ? p.a_x0 : p.a_x1;
        hi_x = (p.a_x0 < p.a_x1) ? p.a_x1 : p.a_x0;
        lo_y = (p.a_y0 < p.a_y1) ? p.a_y0 : p.a_y1;
        hi_y = (p.a_y0 < p.a_y1) ? p.a_y1 : p.a_y0;
        case ($urandom_range(0, 3))
            0:
            begin
                p.b_x0 = pick_coord(scale);
                p.b_y0 = pick_coord(scale);
                p.b_x1 = pick_coord(scale);
                p.b_y1 = pick_coord(scale);
            end
            1:
            begin
                p.b_x0 = hi_x + coord_t'($urandom_range(0, 4)) - 2;
                p.b_x1 = p.b_x0 + coord_t'($urandom_range(0, 12));
                p.b_y0 = lo_y + coord_t'($urandom_range(0, 8)) - 4;
                p.b_y1 = hi_y + coord_t'($urandom_range(0, 8)) - 4;
            end
            2:
            begin
                dx = coord_t'($urandom_range(0, 30)) - 15;
                dy = coord_t'($urandom_range(0, 30)) - 15;
                p.b_x0 = p.a_x0 + dx;
                p.b_y0 = p.a_y0 + dy;
                p.b_x1 = p.a_x1 + dx;
                p.b_y1 = p.a_y1 + dy;
            end
            default:
            begin
                p.b_x0 = lo_x - coord_t'($urandom_range(0, 4)) + 1;
                p.b_y0 = lo_y - coord_t'($urandom_range(0, 4)) + 1;
                p.b_x1 = hi_x + coord_t'($urandom_range(0, 4)) - 1;
                p.b_y1 = hi_y + coord_t'($urandom_range(0, 4)) - 1;
            end
        endcase
        if ($urandom_range(0, 1))
        begin
            t = p.b_x0;
            p.b_x0 = p.b_x1;
            p.b_x1 = t;
        end
        if ($urandom_range(0, 1))
        begin
            t = p.b_y0;
            p.b_y0 = p.b_y1;
            p.b_y1 = t;
        end
        return p;
    endfunction

    task automatic push_pair(in_beat_t b);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            pads.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pads.valid <= 1'b1;
        pads.beat  <= b;
        do @(posedge clk); while (!pads.ready);
        pairs_sent++;
    endtask

    task automatic drain();
        pads.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_mode(logic [MODE_W-1:0] m);
        cfg.valid <= 1'b1;
        cfg.data  <= m;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // result sink: random stall bursts, one long hold-off on request
    initial
    begin
        result.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_long = 1'b0;
                result.ready <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                result.ready <= 1'b1;
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        pads.valid <= 1'b0;
        pads.beat  <= '0;
        cfg.valid  <= 1'b0;
        cfg.data   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pairs under the reset mode
        push_pair(pair_of(0, 0, 10, 10, 1'b0, 0, 0, 10, 10, 1'b0));
        push_pair(pair_of(0, 0, 10, 10, 1'b0, 10, 0, 20, 10, 1'b0));
        push_pair(pair_of(0, 0, 10, 10, 1'b0, 11, 0, 20, 10, 1'b0));
        push_pair(pair_of(10, 10, 0, 0, 1'b0, -5, -5, 15, 15, 1'b1));
        push_pair(pair_of(C_MIN, C_MIN, C_MAX, C_MAX, 1'b0, C_MAX, C_MAX, C_MIN, C_MIN, 1'b1));
        push_pair(pair_of(C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, C_MIN, C_MIN, C_MAX, C_MAX, 1'b1));
        push_pair(pair_of(C_MIN, C_MIN, C_MIN, C_MIN, 1'b1, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1));
        push_pair(pair_of(5, 5, 5, 5, 1'b1, 5, 5, 5, 5, 1'b1));
        push_pair(pair_of(5, 5, 5, 5, 1'b1, 6, 5, 6, 5, 1'b1));
        push_pair(pair_of(0, 0, 20, 6, 1'b1, 20, 3, 30, 4, 1'b0));
        push_pair(pair_of(0, 0, 6, 20, 1'b1, 3, 20, 4, 30, 1'b0));
        push_pair(pair_of(-3, -3, 3, 3, 1'b1, 1, 2, 5, 6, 1'b1));
        push_pair(pair_of(0, 0, 10, 10, 1'b1, 10, 10, 20, 20, 1'b0));
        push_pair(pair_of(0, -5, 0, 5, 1'b0, -5, 0, 5, 0, 1'b0));
        push_pair(pair_of(0, 0, 5, 30, 1'b1, 5, 10, 9, 12, 1'b1));
        push_pair(pair_of(C_MAX - 1, 0, C_MAX, 5, 1'b1, C_MIN, 0, C_MIN + 1, 5, 1'b1));
        push_pair(pair_of(-20, -20, -10, -10, 1'b0, -10, -30, -1, -20, 1'b1));
        push_pair(pair_of(-1, -1, -1, -1, 1'b0, -1, -1, -1, -1, 1'b0));
        push_pair(pair_of(2, 2, 8, 8, 1'b1, 2, 2, 8, 8, 1'b1));
        push_pair(pair_of(C_MIN, 0, C_MAX, 1, 1'b1, 0, 1, 0, 1, 1'b1));
        push_pair(pair_of(C_MIN, C_MIN, C_MAX, C_MAX, 1'b1, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1));
        push_pair(pair_of(C_MAX, C_MAX, C_MAX - 7, C_MAX - 7, 1'b1, 0, 0, C_MAX, C_MAX, 1'b1));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            set_mode(phase_mode[ph]);
            if (ph == PHASES - 1)
            begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end
            for (int n = 0; n < PHASE_PAIRS; n++)
            begin
                if (ph == 1 && n == 40)
                begin
                    hold_long = 1'b1;
                end
                if (ph == 3 && n == PHASE_PAIRS / 2)
                begin
                    drain();
                end
                push_pair(rand_pair());
            end
        end

        drain();
        repeat (FLUSH_CYCLES) @(posedge clk);
        $display("Sent %0d pad pairs over touch, strict, any and spare modes; checked %0d results",
                 pairs_sent, checked);
        $display("(%0d overlapping, %0d with pad a inside pad b).", hits, enclosed);
        if (fails == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
